### rtl/block_psnr_meter_macros.svh
// Assertion macros for the PSNR meter RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BLOCK_PSNR_METER_MACROS_SVH
`define BLOCK_PSNR_METER_MACROS_SVH

// same-cycle implication
`define PSNRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSNRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/psnrm_pkg.sv
// Shared types and constants of the PSNR meter.
// No dependencies; used by psnrm_ctrl, psnrm_dp and block_psnr_meter.
`timescale 1ns / 1ps
`default_nettype none

package psnrm_pkg;

  localparam int MAX_PIXELS = 4096;
  localparam int LOG_FRAC   = 28;

  localparam logic [15:0] PEAK_SQ  = 16'd65025;
  localparam logic [14:0] CAP_Q8   = 15'd25344;
  localparam logic [4:0]  E_START  = 5'd30;
  localparam logic [4:0]  ITER_LAST = 5'(LOG_FRAC - 1);

  // 10*log10(2) in Q32, split in two 17-bit halves
  localparam logic [33:0] TEN_LOG10_2_Q32 = 34'd12929139865;
  localparam logic [16:0] K_LO = TEN_LOG10_2_Q32[16:0];
  localparam logic [16:0] K_HI = TEN_LOG10_2_Q32[33:17];

  typedef struct packed {
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic       is_last;
  } psnrm_in_t;

  typedef struct packed {
    logic [14:0] psnr_q8;
    logic        identical;
    logic [27:0] sum_sq;
    logic [12:0] pixel_total;
    logic        overflow;
  } psnrm_out_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LOAD,
    ST_NORM,
    ST_SQR,
    ST_DIFF,
    ST_MLO,
    ST_MADD,
    ST_DONE
  } psnrm_state_t;

  typedef struct packed {
    logic acc;
    logic log_load;
    logic log_sel;
    logic log_norm;
    logic log_sqr;
    logic save_ln;
    logic diff;
    logic mul_lo;
    logic mul_add;
    logic finish;
  } psnrm_cmd_t;

  typedef struct packed {
    logic sum_zero;
    logic norm_done;
  } psnrm_sts_t;

endpackage

`default_nettype wire

### rtl/psnrm_ctrl.sv
// Sequencer of the PSNR meter: accumulate, two log2 passes, scale, emit.
// Depends on psnrm_pkg and block_psnr_meter_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "block_psnr_meter_macros.svh"

module psnrm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_last,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire psnrm_pkg::psnrm_sts_t sts,
  output psnrm_pkg::psnrm_cmd_t     cmd
);

  psnrm_pkg::psnrm_state_t state_r, state_nxt;
  logic       phase_r, phase_nxt;
  logic [4:0] itc_r, itc_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit;

  assign emit = (state_r == psnrm_pkg::ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    itc_nxt   = '0;
    unique case (state_r)
      psnrm_pkg::ST_ACC: begin
        phase_nxt = 1'b0;
        if (in_valid && in_last) state_nxt = psnrm_pkg::ST_LOAD;
      end
      psnrm_pkg::ST_LOAD: begin
        state_nxt = sts.sum_zero ? psnrm_pkg::ST_DONE : psnrm_pkg::ST_NORM;
      end
      psnrm_pkg::ST_NORM: begin
        if (sts.norm_done) state_nxt = psnrm_pkg::ST_SQR;
      end
      psnrm_pkg::ST_SQR: begin
        itc_nxt = itc_r + 5'd1;
        if (itc_r == psnrm_pkg::ITER_LAST) begin
          itc_nxt = '0;
          if (phase_r) begin
            state_nxt = psnrm_pkg::ST_DIFF;
          end else begin
            phase_nxt = 1'b1;
            state_nxt = psnrm_pkg::ST_LOAD;
          end
        end
      end
      psnrm_pkg::ST_DIFF: state_nxt = psnrm_pkg::ST_MLO;
      psnrm_pkg::ST_MLO:  state_nxt = psnrm_pkg::ST_MADD;
      psnrm_pkg::ST_MADD: state_nxt = psnrm_pkg::ST_DONE;
      psnrm_pkg::ST_DONE: begin
        if (emit) state_nxt = psnrm_pkg::ST_ACC;
      end
      default: state_nxt = psnrm_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      psnrm_pkg::ST_ACC: begin
        in_ready = 1'b1;
        cmd.acc  = in_valid;
      end
      psnrm_pkg::ST_LOAD: begin
        cmd.log_load = !sts.sum_zero;
        cmd.log_sel  = phase_r;
        cmd.save_ln  = phase_r;
      end
      psnrm_pkg::ST_NORM: cmd.log_norm = 1'b1;
      psnrm_pkg::ST_SQR:  cmd.log_sqr  = 1'b1;
      psnrm_pkg::ST_DIFF: cmd.diff     = 1'b1;
      psnrm_pkg::ST_MLO:  cmd.mul_lo   = 1'b1;
      psnrm_pkg::ST_MADD: cmd.mul_add  = 1'b1;
      psnrm_pkg::ST_DONE: cmd.finish   = emit;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psnrm_pkg::ST_ACC;
      phase_r     <= 1'b0;
      itc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      itc_r       <= itc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `PSNRM_ASSERT_NOW(a_rise_from_done, $rose(out_valid_r), $past(state_r) == psnrm_pkg::ST_DONE, "result word raised outside done")
  `PSNRM_ASSERT_NEXT(a_last_starts_calc, in_valid && in_ready && in_last, state_r == psnrm_pkg::ST_LOAD, "last word did not start calculation")
  `PSNRM_ASSERT_NEXT(a_sqr_exit, state_r == psnrm_pkg::ST_SQR && itc_r == psnrm_pkg::ITER_LAST, state_r == psnrm_pkg::ST_LOAD || state_r == psnrm_pkg::ST_DIFF, "squaring pass did not end after its last step")

endmodule

`default_nettype wire

### rtl/psnrm_dp.sv
// Datapath of the PSNR meter: accumulators, shared log2 unit, scaling, result word.
// Depends on psnrm_pkg and block_psnr_meter_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "block_psnr_meter_macros.svh"

module psnrm_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire psnrm_pkg::psnrm_in_t  in_data,
  input  wire psnrm_pkg::psnrm_cmd_t cmd,
  output psnrm_pkg::psnrm_sts_t      sts,
  output psnrm_pkg::psnrm_out_t      out_data
);

  logic [27:0] sum_r;
  logic [12:0] cnt_r;
  logic        ovf_r;
  logic [30:0] m_r;
  logic [4:0]  e_r;
  logic [27:0] frac_r;
  logic [32:0] ln_r;
  logic [24:0] l20_r;
  logic [41:0] pp_lo_r, pp_hi_r;
  logic [58:0] macc_r;
  psnrm_pkg::psnrm_out_t out_r;

  logic [7:0]  dif;
  logic [15:0] dsq;
  logic [28:0] pk;
  logic [61:0] sq;
  logic [31:0] sqs;
  logic [32:0] ld;
  logic [32:0] ldif;
  logic [14:0] q;
  logic [14:0] psnr;

  assign dif  = (in_data.pixel_a > in_data.pixel_b) ? (in_data.pixel_a - in_data.pixel_b)
                                                    : (in_data.pixel_b - in_data.pixel_a);
  assign dsq  = dif * dif;
  assign pk   = psnrm_pkg::PEAK_SQ * cnt_r;
  assign sq   = m_r * m_r;
  assign sqs  = sq[61:30];
  assign ld   = {e_r, frac_r};
  assign ldif = ln_r - ld;
  assign q    = macc_r[58:44];
  assign psnr = (sum_r == '0 || q > psnrm_pkg::CAP_Q8) ? psnrm_pkg::CAP_Q8 : q;

  assign sts.sum_zero  = (sum_r == '0);
  assign sts.norm_done = m_r[30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.finish) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.acc) begin
      if (cnt_r < 13'(psnrm_pkg::MAX_PIXELS)) begin
        sum_r <= sum_r + 28'(dsq);
        cnt_r <= cnt_r + 13'd1;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.log_load) begin
      m_r    <= cmd.log_sel ? {3'b000, sum_r} : {2'b00, pk};
      e_r    <= psnrm_pkg::E_START;
      frac_r <= '0;
    end else if (cmd.log_norm && !m_r[30]) begin
      m_r <= {m_r[29:0], 1'b0};
      e_r <= e_r - 5'd1;
    end else if (cmd.log_sqr) begin
      if (sqs[31]) begin
        m_r    <= sqs[31:1];
        frac_r <= {frac_r[26:0], 1'b1};
      end else begin
        m_r    <= sqs[30:0];
        frac_r <= {frac_r[26:0], 1'b0};
      end
    end
    if (cmd.save_ln) ln_r <= ld;
    if (cmd.diff) l20_r <= (ln_r > ld) ? ldif[32:8] : '0;
    if (cmd.mul_lo) begin
      pp_lo_r <= l20_r * psnrm_pkg::K_LO;
      pp_hi_r <= l20_r * psnrm_pkg::K_HI;
    end
    if (cmd.mul_add) macc_r <= 59'(pp_lo_r) + {pp_hi_r, 17'd0};
    if (cmd.finish) begin
      out_r.psnr_q8     <= psnr;
      out_r.identical   <= (sum_r == '0);
      out_r.sum_sq      <= sum_r;
      out_r.pixel_total <= cnt_r;
      out_r.overflow    <= ovf_r;
    end
  end

  assign out_data = out_r;

  `PSNRM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= 13'(psnrm_pkg::MAX_PIXELS), "pair count beyond capacity")
  `PSNRM_ASSERT_NOW(a_sqr_normed, cmd.log_sqr, m_r[30], "squaring on unnormalized mantissa")
  `PSNRM_ASSERT_NEXT(a_finish_clears, cmd.finish, sum_r == '0 && cnt_r == '0 && !ovf_r, "block state not cleared after result")

endmodule

`default_nettype wire

### rtl/block_psnr_meter.sv
// PSNR meter for 8-bit blocks: accumulates pixel pairs, then computes PSNR once per block.
// Uses psnrm_pkg, psnrm_ctrl and psnrm_dp.
// Pixel pairs are taken one per cycle. After the word marked last, input stalls while one
// shared log2 unit (one 31x31 squaring per cycle) computes log2(65025*count) and log2(sum),
// then a split multiply (low and high halves of the constant) scales to dB. When the sum is
// zero the log passes are skipped; otherwise each log pass normalizes its operand with left
// shifts (3 to 15 and 3 to 30) and then takes 28 squaring steps. A finished result waits
// in an output register; the next block starts once it has been loaded there.
`timescale 1ns / 1ps
`default_nettype none

module block_psnr_meter (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire psnrm_pkg::psnrm_in_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output psnrm_pkg::psnrm_out_t      out_data
);

  psnrm_pkg::psnrm_cmd_t cmd;
  psnrm_pkg::psnrm_sts_t sts;

  psnrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.is_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  psnrm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for block_psnr_meter: streams pixel-pair blocks and predicts every result.
// Depends on psnrm_pkg for the word types and constants, and on the block_psnr_meter RTL.
`timescale 1ns / 1ps

module tb;
  import psnrm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;
  localparam int LONG_HOLD = 500;

  typedef enum int {
    MIX_RANDOM,
    MIX_EQUAL,
    MIX_NEAR,
    MIX_RAIL,
    MIX_SWING
  } pixel_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  psnrm_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  psnrm_out_t out_data;

  psnrm_in_t pixel_feed[$];
  psnrm_out_t psnr_results_due[$];
  psnrm_out_t want;

  logic [27:0] sq_sum = '0;
  logic [12:0] pair_total = '0;
  logic dropped_pairs = 1'b0;

  int send_idle_pct = 32;
  int recv_idle_pct = 72;
  int phase = 0;
  int recv_hold_left = 0;
  bit recv_hold_done = 1'b0;
  int errors = 0;
  int words_sent = 0;
  int results_checked = 0;
  int cycle_count = 0;

  block_psnr_meter uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] log2_q28(input logic [63:0] v);
    int unsigned e;
    int i;
    logic [63:0] m;
    logic [63:0] frac;
    e = 0;
    frac = '0;
    if (v == 0) return '0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    if (e <= 30) m = v << (30 - e);
    else m = v >> (e - 30);
    for (i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << LOG_FRAC) | frac;
  endfunction

  function automatic logic [14:0] psnr_db_q8(input logic [27:0] sum, input logic [12:0] cnt);
    logic [63:0] l_num;
    logic [63:0] l_den;
    logic [63:0] q;
    l_num = log2_q28(64'(cnt) * 64'(PEAK_SQ));
    l_den = log2_q28(64'(sum));
    if (l_num <= l_den) return '0;
    q = (((l_num - l_den) >> 8) * 64'(TEN_LOG10_2_Q32)) >> 44;
    if (q > 64'(CAP_Q8)) q = 64'(CAP_Q8);
    return q[14:0];
  endfunction

  task automatic absorb_pair(input psnrm_in_t w);
    logic [7:0] d;
    psnrm_out_t r;
    d = (w.pixel_a > w.pixel_b) ? w.pixel_a - w.pixel_b : w.pixel_b - w.pixel_a;
    if (pair_total < MAX_PIXELS) begin
      sq_sum = sq_sum + 28'(d) * 28'(d);
      pair_total = pair_total + 13'd1;
    end else begin
      dropped_pairs = 1'b1;
    end
    if (w.is_last) begin
      r.identical = (sq_sum == 0);
      r.psnr_q8 = r.identical ? CAP_Q8 : psnr_db_q8(sq_sum, pair_total);
      r.sum_sq = sq_sum;
      r.pixel_total = pair_total;
      r.overflow = dropped_pairs;
      psnr_results_due.insert(psnr_results_due.size(), r);
      sq_sum = '0;
      pair_total = '0;
      dropped_pairs = 1'b0;
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] w, input logic [31:0] g);
    if (w !== g) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, w, g);
    end
  endtask

  task automatic push_pair(input int a, input int b, input bit last);
    psnrm_in_t w;
    w.pixel_a = a[7:0];
    w.pixel_b = b[7:0];
    w.is_last = last;
    pixel_feed.insert(pixel_feed.size(), w);
  endtask

  task automatic push_block(input int len, input pixel_mix_t mix);
    int k;
    int a;
    int b;
    for (k = 0; k < len; k++) begin
      a = $urandom_range(255);
      case (mix)
        MIX_RANDOM: b = $urandom_range(255);
        MIX_EQUAL: b = a;
        MIX_NEAR: begin
          b = a + $urandom_range(6) - 3;
          if (b < 0) b = 0;
          if (b > 255) b = 255;
        end
        MIX_RAIL: begin
          a = $urandom_range(1) ? 255 : 0;
          b = $urandom_range(1) ? 255 : 0;
        end
        default: begin
          a = $urandom_range(1) ? 255 : 0;
          b = 255 - a;
        end
      endcase
      push_pair(a, b, k == len - 1);
    end
  endtask

  task automatic push_random_blocks(input int target);
    int pushed;
    int len;
    pushed = 0;
    while (pushed < target) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(300, 100) : $urandom_range(24, 1);
      push_block(len, pixel_mix_t'($urandom_range(3)));
      pushed += len;
    end
  endtask

  task automatic wait_drained();
    while (pixel_feed.size() != 0 || in_valid) @(posedge clk);
    while (psnr_results_due.size() != 0) @(posedge clk);
  endtask

  // driver: predict on acceptance, then offer the next word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_pair(in_data);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pixel_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check result words and pace out_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (psnr_results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, got %p", $time, out_data);
        end else begin
          want = psnr_results_due.pop_front();
          check_field("psnr_q8", want.psnr_q8, out_data.psnr_q8);
          check_field("identical", want.identical, out_data.identical);
          check_field("sum_sq", want.sum_sq, out_data.sum_sq);
          check_field("pixel_total", want.pixel_total, out_data.pixel_total);
          check_field("overflow", want.overflow, out_data.overflow);
          results_checked++;
        end
      end
      if (recv_hold_left != 0) begin
        recv_hold_left <= recv_hold_left - 1;
        out_ready <= 1'b0;
      end else if (phase == 2 && !recv_hold_done) begin
        recv_hold_left <= LONG_HOLD;
        recv_hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("block_psnr_meter verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // single-pair blocks at the rails, equal and unequal, then short multi-pair blocks
    push_pair(0, 255, 1'b1);
    push_pair(255, 0, 1'b1);
    push_pair(0, 0, 1'b1);
    push_pair(255, 255, 1'b1);
    push_pair(1, 0, 1'b1);
    push_pair(0, 1, 1'b0);
    push_pair(255, 254, 1'b0);
    push_pair(128, 128, 1'b0);
    push_pair(127, 129, 1'b1);
    push_pair(8'hAA, 8'hAA, 1'b0);
    push_pair(8'h55, 8'h55, 1'b0);
    push_pair(8'hFF, 8'hFF, 1'b0);
    push_pair(8'h00, 8'h00, 1'b1);
    push_pair(8'hAA, 8'h55, 1'b0);
    push_pair(8'h55, 8'hAA, 1'b1);
    push_random_blocks(500);
    wait_drained();

    phase = 1;
    send_idle_pct = 72;
    recv_idle_pct = 32;
    // long block with peak error on every pair
    push_block(256, MIX_SWING);
    push_random_blocks(400);
    wait_drained();

    phase = 2;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_blocks(480);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d pixel words across random, equal, near and rail blocks plus one peak block;",
             words_sent);
    $display("checked %0d block results, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("block_psnr_meter verification clean");
    end else begin
      $display("block_psnr_meter verification failed");
    end
    $finish;
  end

endmodule
